// File: rtl/tlfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light fade sequencer package
// Shared widths, fade and blink timing, phase colors, register indexes and
// the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package tlfs_pkg;

    // Field and state widths
    localparam int DUR_W       = 16;
    localparam int LEVEL_W     = 8;
    localparam int COLOR_W     = 3 * LEVEL_W;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 4;

    // Fade length in ticks (power of two, so the divide is a shift)
    localparam int FADE_TICKS = 16;
    localparam int FADE_SHIFT = $clog2(FADE_TICKS);
    localparam int FADE_W     = $clog2(FADE_TICKS + 1);

    // Crosswalk blink timing
    localparam int BLINK_OFF_TICKS    = 4;
    localparam int BLINK_PERIOD_TICKS = 16;

    // Phase colors, 0xRRGGBB
    localparam logic [COLOR_W-1:0] COLOR_STOP      = 24'h611E3C;
    localparam logic [COLOR_W-1:0] COLOR_GO        = 24'h229622;
    localparam logic [COLOR_W-1:0] COLOR_WARNING   = 24'hFFB200;
    localparam logic [COLOR_W-1:0] COLOR_CROSSWALK = 24'h001030;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_DURATION      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GO_DURATION        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARNING_DURATION   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CROSSWALK_DURATION = 4'd3;

    // Duration reset values
    localparam logic [DUR_W-1:0] DUR_RESET_STOP      = 16'd80;
    localparam logic [DUR_W-1:0] DUR_RESET_GO        = 16'd80;
    localparam logic [DUR_W-1:0] DUR_RESET_WARNING   = 16'd48;
    localparam logic [DUR_W-1:0] DUR_RESET_CROSSWALK = 16'd176;

    // One timer tick
    typedef struct packed {
        logic button_hit;
        logic touch_pressed;
    } tlfs_in_t;

    // One set of PWM levels and the phase after the tick
    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [PHASE_W-1:0] light_phase;
    } tlfs_out_t;

endpackage

// File: rtl/traffic_light_fade_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light fade sequencer
// Walks stop, go, warning and crosswalk phases on timer ticks, fades the RGB
// PWM levels between phase colors and blinks the crosswalk color.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one timer tick; each tick yields
// exactly one result transfer with the three PWM levels and the new phase.
// The block takes one tick per clock cycle while the output is not stalled:
// a tick sits in an input register, the whole phase, fade and blink update
// runs combinationally against the state registers, and the result lands in
// an output register. The combinational state update (count compare, phase
// select, two small multiplies per color channel) sets that rate. Durations
// reset to 80, 80, 48 and 176 ticks; the user must write them through the
// configuration port only while no tick is in flight, as the block does not
// enforce it. Indexes above three are ignored; the cfg port is always ready.
module traffic_light_fade_sequencer
    import tlfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  tlfs_in_t               in_data,

    output logic                   out_valid,
    input  logic                   out_stall,
    output tlfs_out_t              out_data,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]       cfg_data
);

    typedef enum logic [PHASE_W-1:0] {
        PHASE_STOP,
        PHASE_GO,
        PHASE_WARNING,
        PHASE_CROSSWALK
    } phase_t;

    // Color shown in each phase
    function automatic logic [COLOR_W-1:0] phase_color(input phase_t ph);
        logic [COLOR_W-1:0] c;
        unique case (ph)
            PHASE_STOP:      c = COLOR_STOP;
            PHASE_GO:        c = COLOR_GO;
            PHASE_WARNING:   c = COLOR_WARNING;
            PHASE_CROSSWALK: c = COLOR_CROSSWALK;
            default:         c = COLOR_STOP;
        endcase
        return c;
    endfunction

    // Phase that follows on timeout
    function automatic phase_t phase_after(input phase_t ph);
        phase_t n;
        unique case (ph)
            PHASE_STOP:      n = PHASE_GO;
            PHASE_GO:        n = PHASE_WARNING;
            PHASE_WARNING:   n = PHASE_STOP;
            PHASE_CROSSWALK: n = PHASE_GO;
            default:         n = PHASE_STOP;
        endcase
        return n;
    endfunction

    // Linear fade of one channel: (from*(F-t) + to*t) / F
    function automatic logic [LEVEL_W-1:0] fade_channel(
        input logic [LEVEL_W-1:0] from,
        input logic [LEVEL_W-1:0] to,
        input logic [FADE_W-1:0]  t
    );
        logic [FADE_W-1:0]         t_rest;
        logic [LEVEL_W+FADE_W-1:0] sum;
        t_rest = FADE_W'(FADE_TICKS) - t;
        sum    = (LEVEL_W+FADE_W)'(from) * (LEVEL_W+FADE_W)'(t_rest)
               + (LEVEL_W+FADE_W)'(to) * (LEVEL_W+FADE_W)'(t);
        return sum[FADE_SHIFT +: LEVEL_W];
    endfunction

    // Registers
    logic               in_valid_reg;
    tlfs_in_t           in_data_reg;
    logic               out_valid_reg;
    tlfs_out_t          out_data_reg;
    logic [DUR_W-1:0]   dur_reg [4];
    phase_t             phase_reg;
    logic [DUR_W-1:0]   tick_count_reg;
    logic [COLOR_W-1:0] start_color_reg;
    logic [COLOR_W-1:0] fade_color_reg;
    logic [DUR_W-1:0]   blink_mark_reg;
    logic [COLOR_W-1:0] level_hold_reg;

    // Next values
    phase_t             phase_next;
    logic [DUR_W-1:0]   tick_count_next;
    logic [COLOR_W-1:0] start_color_next;
    logic [COLOR_W-1:0] fade_color_next;
    logic [DUR_W-1:0]   blink_mark_next;
    logic [COLOR_W-1:0] level_hold_next;

    // Tick update signals
    logic               press;
    logic [DUR_W-1:0]   count;
    logic               timeout;
    logic [COLOR_W-1:0] target;
    logic [COLOR_W-1:0] fade_rgb;
    logic [DUR_W-1:0]   blink_delta;

    // Handshake
    logic in_accept;
    logic out_free;
    logic advance;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Phase move, fade and blink for the tick in the input register
    always_comb
    begin
        press            = in_data_reg.button_hit | in_data_reg.touch_pressed;
        count            = tick_count_reg + DUR_W'(1);
        timeout          = (count == dur_reg[phase_reg]);
        phase_next       = phase_reg;
        tick_count_next  = count;
        start_color_next = start_color_reg;

        if (timeout)
        begin
            start_color_next = phase_color(phase_reg);
            phase_next       = phase_after(phase_reg);
            tick_count_next  = '0;
        end
        else if (press && phase_reg != PHASE_CROSSWALK)
        begin
            start_color_next = fade_color_reg;
            phase_next       = PHASE_CROSSWALK;
            tick_count_next  = '0;
        end

        target   = phase_color(phase_next);
        fade_rgb = {
            fade_channel(start_color_next[2*LEVEL_W +: LEVEL_W], target[2*LEVEL_W +: LEVEL_W],
                         tick_count_next[FADE_W-1:0]),
            fade_channel(start_color_next[LEVEL_W +: LEVEL_W], target[LEVEL_W +: LEVEL_W],
                         tick_count_next[FADE_W-1:0]),
            fade_channel(start_color_next[0 +: LEVEL_W], target[0 +: LEVEL_W],
                         tick_count_next[FADE_W-1:0])
        };
        blink_delta     = tick_count_next - blink_mark_reg;
        fade_color_next = fade_color_reg;
        blink_mark_next = blink_mark_reg;

        if (tick_count_next <= DUR_W'(FADE_TICKS))
        begin
            // fade in progress; crosswalk keeps the blink mark on the count
            level_hold_next = fade_rgb;
            fade_color_next = fade_rgb;
            if (phase_next == PHASE_CROSSWALK)
            begin
                blink_mark_next = tick_count_next;
            end
        end
        else if (phase_next == PHASE_CROSSWALK)
        begin
            // blink: dark first, then color, repeat last levels at period end
            if (blink_delta < DUR_W'(BLINK_OFF_TICKS))
            begin
                level_hold_next = '0;
            end
            else if (blink_delta >= DUR_W'(BLINK_PERIOD_TICKS))
            begin
                blink_mark_next = tick_count_next;
                level_hold_next = level_hold_reg;
            end
            else
            begin
                level_hold_next = target;
            end
        end
        else
        begin
            level_hold_next = target;
        end
    end

    // Hold state, configuration and the input and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_data_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            dur_reg[0]      <= DUR_RESET_STOP;
            dur_reg[1]      <= DUR_RESET_GO;
            dur_reg[2]      <= DUR_RESET_WARNING;
            dur_reg[3]      <= DUR_RESET_CROSSWALK;
            phase_reg       <= PHASE_STOP;
            tick_count_reg  <= '0;
            start_color_reg <= COLOR_STOP;
            fade_color_reg  <= '0;
            blink_mark_reg  <= '0;
            level_hold_reg  <= '0;
        end
        else
        begin
            // capture a tick transfer
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= in_data;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // advance state and load the result
            if (advance)
            begin
                phase_reg                 <= phase_next;
                tick_count_reg            <= tick_count_next;
                start_color_reg           <= start_color_next;
                fade_color_reg            <= fade_color_next;
                blink_mark_reg            <= blink_mark_next;
                level_hold_reg            <= level_hold_next;
                out_valid_reg             <= 1'b1;
                out_data_reg.red_level    <= level_hold_next[2*LEVEL_W +: LEVEL_W];
                out_data_reg.green_level  <= level_hold_next[LEVEL_W +: LEVEL_W];
                out_data_reg.blue_level   <= level_hold_next[0 +: LEVEL_W];
                out_data_reg.light_phase  <= phase_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // write a duration register, drop unknown indexes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_STOP_DURATION:      dur_reg[0] <= cfg_data;
                    CFG_GO_DURATION:        dur_reg[1] <= cfg_data;
                    CFG_WARNING_DURATION:   dur_reg[2] <= cfg_data;
                    CFG_CROSSWALK_DURATION: dur_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // A phase move always restarts the tick count
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (timeout || (press && phase_reg != PHASE_CROSSWALK))
        |=> tick_count_reg == '0)
    else $error("tick count not cleared on phase move");

    // A press outside crosswalk without timeout enters crosswalk
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !timeout && press && phase_reg != PHASE_CROSSWALK
        |=> phase_reg == PHASE_CROSSWALK)
    else $error("press did not enter crosswalk");

    // Every processed tick presents a result with the state's phase
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && out_data_reg.light_phase == phase_reg)
    else $error("result phase does not match state");

    // The input side stalls only while a tick waits behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
    else $error("input stalled without a blocked result");

endmodule
